@@ hw/rtl/sti_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_pkg: shared types and constants of the thread sample interleaver
// Word width, register codes, reset values and the per-bit route entry
// that the route table hands to each lane.
// ----------------------------------------------------------------------------
package sti_pkg;

  localparam int WORD_W          = 32;
  localparam int THR_W           = 3;   // thread select, enough for up to eight threads
  localparam int POS_W           = 5;   // bit position inside one 32-bit word
  localparam int CFG_W           = 4;
  localparam int CFG_IDX_W       = 1;
  localparam int MAX_THREADS_DEF = 8;

  localparam logic [CFG_W-1:0] THREAD_COUNT_RST = 4'd2;
  localparam logic [CFG_W-1:0] SAMPLE_BITS_RST  = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THREAD_COUNT = 1'b0,
    CFG_SAMPLE_BITS  = 1'b1
  } cfg_idx_t;

  // Source of one output bit: which thread word and which bit of it.
  typedef struct packed {
    logic             vld;
    logic [THR_W-1:0] thr;
    logic [POS_W-1:0] pos;
  } route_t;

  // Status from the route table to the top level.
  typedef struct packed {
    logic cfg_error;
    logic map_busy;
  } route_stat_t;

endpackage

@@ hw/rtl/sti_route.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_route: configuration registers and bit route table
// Holds thread_count and sample_bits and rebuilds, over three register
// stages, the source of every output bit of every lane.
// ----------------------------------------------------------------------------
module sti_route #(
  parameter int MAX_THREADS = sti_pkg::MAX_THREADS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sti_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [sti_pkg::CFG_W-1:0]   cfg_wdata,
  output sti_pkg::route_t             map_o [MAX_THREADS][sti_pkg::WORD_W],
  output sti_pkg::route_stat_t        stat_o
);
  import sti_pkg::*;

  localparam logic [1:0]       MAP_LAT = 2'd3;
  localparam logic [CFG_W-1:0] MAX_TC  = CFG_W'(MAX_THREADS);

  // Timesteps per output word, by thread count (row) and sample width.
  // Each row packs the entries for sample widths 8 down to 1.
  localparam logic [39:0] SPO_TAB [16] = '{
    2:       {5'd2, 5'd2, 5'd2, 5'd3, 5'd4, 5'd5, 5'd8, 5'd16},
    3:       {5'd1, 5'd1, 5'd1, 5'd2, 5'd2, 5'd3, 5'd5, 5'd10},
    4:       {5'd1, 5'd1, 5'd1, 5'd1, 5'd2, 5'd2, 5'd4, 5'd8},
    5:       {5'd0, 5'd0, 5'd1, 5'd1, 5'd1, 5'd2, 5'd3, 5'd6},
    6:       {5'd0, 5'd0, 5'd0, 5'd1, 5'd1, 5'd1, 5'd2, 5'd5},
    7:       {5'd0, 5'd0, 5'd0, 5'd0, 5'd1, 5'd1, 5'd2, 5'd4},
    8:       {5'd0, 5'd0, 5'd0, 5'd0, 5'd1, 5'd1, 5'd2, 5'd4},
    default: 40'd0
  };

  typedef struct packed {
    logic [4:0] q;
    logic [4:0] r;
  } divmod_t;

  function automatic logic [8:0] recip(input logic [CFG_W-1:0] v);
    logic [8:0] f;
    unique case (v)
      4'd1:    f = 9'd256;
      4'd2:    f = 9'd128;
      4'd3:    f = 9'd85;
      4'd4:    f = 9'd64;
      4'd5:    f = 9'd51;
      4'd6:    f = 9'd42;
      4'd7:    f = 9'd36;
      4'd8:    f = 9'd32;
      default: f = 9'd0;
    endcase
    return f;
  endfunction

  // Quotient and remainder of a value below 32 by 1..8: a floor
  // reciprocal is at most one short, so one correction step suffices.
  function automatic divmod_t div_small(input logic [4:0] x, input logic [CFG_W-1:0] v);
    logic [13:0] prod;
    logic [4:0]  q0;
    logic [8:0]  qv;
    logic [8:0]  r0;
    divmod_t     res;
    prod = 14'(x) * 14'(recip(v));
    q0   = prod[12:8];
    qv   = 9'(q0) * 9'(v);
    r0   = 9'(x) - qv;
    if (r0 >= 9'(v)) begin
      res.q = q0 + 5'd1;
      res.r = 5'(r0 - 9'(v));
    end else begin
      res.q = q0;
      res.r = r0[4:0];
    end
    return res;
  endfunction

  logic [CFG_W-1:0] thread_count_r, thread_count_nxt;
  logic [CFG_W-1:0] sample_bits_r, sample_bits_nxt;
  logic [1:0]       busy_cnt_r, busy_cnt_nxt;

  // Stage A: slot and bit-in-sample of every output bit.
  logic [4:0] slot_a_r [WORD_W];
  logic [2:0] rem_a_r  [WORD_W];
  logic [4:0] spo_a_r;
  logic [5:0] span_a_r;
  logic       err_a_r;

  // Stage B: thread and timestep of every output bit.
  logic [THR_W-1:0] thr_b_r [WORD_W];
  logic [3:0]       k_b_r   [WORD_W];
  logic [2:0]       rem_b_r [WORD_W];
  logic             vld_b_r [WORD_W];
  logic [7:0]       base_b_r [MAX_THREADS];
  logic             err_b_r;

  // Stage C: finished table.
  route_t map_r [MAX_THREADS][WORD_W];
  logic   err_c_r;

  logic [4:0] spo_a_nxt;
  logic [8:0] span_full;
  logic       err_a_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    thread_count_nxt = thread_count_r;
    sample_bits_nxt  = sample_bits_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_THREAD_COUNT: thread_count_nxt = cfg_wdata;
        CFG_SAMPLE_BITS:  sample_bits_nxt  = cfg_wdata;
      endcase
    end
    if (cfg_valid) begin
      busy_cnt_nxt = MAP_LAT;
    end else if (busy_cnt_r != 2'd0) begin
      busy_cnt_nxt = busy_cnt_r - 2'd1;
    end else begin
      busy_cnt_nxt = busy_cnt_r;
    end
  end

  always_comb begin
    spo_a_nxt = SPO_TAB[thread_count_r][5*(3'(sample_bits_r - 4'd1)) +: 5];
    span_full = 9'(spo_a_nxt) * 9'(thread_count_r);
    err_a_nxt = (thread_count_r < 4'd2) || (thread_count_r > MAX_TC) ||
                (sample_bits_r == 4'd0) || (sample_bits_r > 4'd8) ||
                (spo_a_nxt == 5'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thread_count_r <= THREAD_COUNT_RST;
      sample_bits_r  <= SAMPLE_BITS_RST;
      busy_cnt_r     <= MAP_LAT;
    end else begin
      thread_count_r <= thread_count_nxt;
      sample_bits_r  <= sample_bits_nxt;
      busy_cnt_r     <= busy_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    divmod_t dm_a;
    divmod_t dm_b;
    logic [11:0] src;
    spo_a_r  <= spo_a_nxt;
    span_a_r <= span_full[5:0];
    err_a_r  <= err_a_nxt;
    err_b_r  <= err_a_r;
    err_c_r  <= err_b_r;
    for (int b = 0; b < WORD_W; b++) begin
      dm_a        = div_small(5'(b), sample_bits_r);
      slot_a_r[b] <= dm_a.q;
      rem_a_r[b]  <= dm_a.r[2:0];
      dm_b        = div_small(slot_a_r[b], thread_count_r);
      thr_b_r[b]  <= dm_b.r[THR_W-1:0];
      k_b_r[b]    <= dm_b.q[3:0];
      rem_b_r[b]  <= rem_a_r[b];
      vld_b_r[b]  <= !err_a_r && (6'(slot_a_r[b]) < span_a_r);
    end
    for (int j = 0; j < MAX_THREADS; j++) begin
      base_b_r[j] <= 8'(spo_a_r) * 8'(j);
      for (int b = 0; b < WORD_W; b++) begin
        src = 12'(base_b_r[j] + 8'(k_b_r[b])) * 12'(sample_bits_r) + 12'(rem_b_r[b]);
        map_r[j][b].vld <= vld_b_r[b] && (CFG_W'(j) < thread_count_r);
        map_r[j][b].thr <= thr_b_r[b];
        map_r[j][b].pos <= src[POS_W-1:0];
      end
    end
  end

  assign map_o            = map_r;
  assign stat_o.cfg_error = err_c_r;
  assign stat_o.map_busy  = (busy_cnt_r != 2'd0);

endmodule

@@ hw/rtl/sti_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_lane: one output word of the corner turn
// Picks every bit of its output word from the thread words as the route
// table directs; bits without a source are zero.
// ----------------------------------------------------------------------------
module sti_lane #(
  parameter int MAX_THREADS = sti_pkg::MAX_THREADS_DEF
) (
  input  logic [sti_pkg::WORD_W-1:0] in_words [MAX_THREADS],
  input  sti_pkg::route_t            map_i [sti_pkg::WORD_W],
  output logic [sti_pkg::WORD_W-1:0] lane_word
);
  import sti_pkg::*;

  always_comb begin
    logic [WORD_W-1:0] w;
    for (int b = 0; b < WORD_W; b++) begin
      w = '0;
      for (int t = 0; t < MAX_THREADS; t++) begin
        if (map_i[b].thr == THR_W'(t)) begin
          w = in_words[t];
        end
      end
      lane_word[b] = map_i[b].vld & w[map_i[b].pos];
    end
  end

endmodule

@@ hw/rtl/sti_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_merge: output register with skid stage
// Gathers the lane words and the error flag into one result word and
// holds it, plus one more in the skid stage, until it is taken.
// ----------------------------------------------------------------------------
module sti_merge #(
  parameter int MAX_THREADS = sti_pkg::MAX_THREADS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   up_valid,
  output logic                                   up_ready,
  input  logic [sti_pkg::WORD_W-1:0]             lane_word [MAX_THREADS],
  input  logic                                   cfg_error,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [MAX_THREADS*sti_pkg::WORD_W-1:0] out_tdata,
  output logic                                   out_tuser
);
  import sti_pkg::*;

  localparam int DATA_W = MAX_THREADS * WORD_W;

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_err_r, out_err_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  logic [DATA_W-1:0] skid_data_r, skid_data_nxt;
  logic              skid_err_r, skid_err_nxt;
  logic [DATA_W-1:0] merged;
  logic              up_fire;

  always_comb begin
    for (int t = 0; t < MAX_THREADS; t++) begin
      merged[t*WORD_W +: WORD_W] = lane_word[t];
    end
  end

  assign up_ready = !skid_valid_r;
  assign up_fire  = up_valid && up_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_err_nxt    = out_err_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    skid_err_nxt   = skid_err_r;
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        out_err_nxt    = skid_err_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = up_fire;
        if (up_fire) begin
          out_data_nxt = merged;
          out_err_nxt  = cfg_error;
        end
      end
    end else if (up_fire) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = merged;
      skid_err_nxt   = cfg_error;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_err_r   <= out_err_nxt;
    skid_data_r <= skid_data_nxt;
    skid_err_r  <= skid_err_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_err_r;

endmodule

@@ hw/rtl/thread_sample_interleave.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thread_sample_interleave: multi-thread to multi-channel corner turn
// Takes one payload word per thread and returns the same number of words
// with the threads' samples interleaved channel by channel.
// ----------------------------------------------------------------------------
// The block accepts one word per clock cycle while in_tready is high and
// registers each result; an output register backed by a skid stage takes
// a further input word while a result waits, so the sustained rate is one
// word per cycle for as long as the output side takes words. Each output
// word is built by its own lane, which selects every bit from the thread
// words through a route table; that table follows from thread_count and
// sample_bits and is rebuilt by a three-stage pipeline, so after reset and
// after every configuration write in_tready stays low until it is rebuilt
// (configuration writes are always taken). Samples sit with sample 0 in
// the low bits. Output word j carries, for each timestep slot k, the
// samples j*spo+k of threads 0 to thread_count-1 in order, where spo is
// floor(floor(32/sample_bits)/thread_count). Unused bits and output words
// at or above thread_count are zero. If the configuration is out of range
// or no timestep fits one word, all output words are zero and the
// config_error flag in out_tuser is set.
// ----------------------------------------------------------------------------
module thread_sample_interleave #(
  parameter int MAX_THREADS = sti_pkg::MAX_THREADS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // tdata, from the lowest bit up: thread_word_0 .. thread_word_{MAX_THREADS-1}
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [MAX_THREADS*sti_pkg::WORD_W-1:0] in_tdata,
  // tdata, from the lowest bit up: merged_word_0 .. merged_word_{MAX_THREADS-1}
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [MAX_THREADS*sti_pkg::WORD_W-1:0] out_tdata,
  // tuser: config_error
  output logic                                   out_tuser,
  // Register 0 is thread_count, register 1 is sample_bits.
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [sti_pkg::CFG_IDX_W-1:0]          cfg_addr,
  input  logic [sti_pkg::CFG_W-1:0]              cfg_wdata
);
  import sti_pkg::*;

  route_t            map [MAX_THREADS][WORD_W];
  route_stat_t       stat;
  logic [WORD_W-1:0] words     [MAX_THREADS];
  logic [WORD_W-1:0] lane_word [MAX_THREADS];
  logic              up_ready;

  // Route table and configuration registers.
  sti_route #(
    .MAX_THREADS (MAX_THREADS)
  ) u_route (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .map_o     (map),
    .stat_o    (stat)
  );

  // Split the input word into the thread words.
  for (genvar t = 0; t < MAX_THREADS; t++) begin : g_split
    assign words[t] = in_tdata[t*WORD_W +: WORD_W];
  end

  // One lane per output word, all working on the same input word.
  for (genvar j = 0; j < MAX_THREADS; j++) begin : g_lane
    sti_lane #(
      .MAX_THREADS (MAX_THREADS)
    ) u_lane (
      .in_words  (words),
      .map_i     (map[j]),
      .lane_word (lane_word[j])
    );
  end

  // Input is held off while the route table is being rebuilt.
  assign in_tready = up_ready && !stat.map_busy;

  sti_merge #(
    .MAX_THREADS (MAX_THREADS)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_tvalid && !stat.map_busy),
    .up_ready   (up_ready),
    .lane_word  (lane_word),
    .cfg_error  (stat.cfg_error),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
